// File: src/hssc_pkg.sv
package hssc_pkg;

    localparam int CmdW     = 16;
    localparam int DutyW    = 16;
    localparam int TpmW     = 10;
    localparam int RampMsW  = 16;
    localparam int RampW    = 26;
    localparam int SlopeW   = 32;
    localparam int PosW     = 32;
    localparam int SecW     = 3;
    localparam int ModeW    = 2;
    localparam int MagW     = 10;
    localparam int DivW     = 32;
    localparam int DivSteps = DivW;
    localparam int DivCntW  = $clog2(DivSteps);
    localparam int MulAW    = 32;
    localparam int MulBW    = 26;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 16;
    localparam int CmdLimit = 1000;

    localparam logic [CfgIdxW-1:0] CfgMaxDuty    = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgTicksPerMs = 1'b1;

    localparam logic [DutyW-1:0] MaxDutyReset = 16'd1000;
    localparam logic [TpmW-1:0]  TpmReset     = 10'd10;
    // ceil(2^36 / 1000): divide a 26-bit product by 1000 with one multiply and a shift
    localparam logic [MulAW-1:0] DutyRecip    = 32'd68719477;
    localparam int               DutyShift    = 36;

    typedef enum logic [2:0] {
        OpTick,
        OpSetPwm,
        OpStartRamp,
        OpEnable,
        OpDisable,
        OpClearPos
    } t_op;

    typedef enum logic [ModeW-1:0] {
        ModeFloat,
        ModeLow,
        ModePwm
    } t_mode;

    localparam logic [1:0] PhaseY = 2'd0;
    localparam logic [1:0] PhaseB = 2'd1;
    localparam logic [1:0] PhaseG = 2'd2;

    typedef struct packed {
        t_mode y;
        t_mode b;
        t_mode g;
    } t_modes;

    function automatic logic [SecW-1:0] hall_sector(input logic a, input logic b,
                                                    input logic c);
        logic [SecW-1:0] s;
        case ({a, b, c})
            3'b001:  s = 3'd1;
            3'b010:  s = 3'd5;
            3'b011:  s = 3'd6;
            3'b100:  s = 3'd3;
            3'b101:  s = 3'd2;
            3'b110:  s = 3'd4;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] pwm_phase(input logic [SecW-1:0] sec, input logic fwd);
        logic [1:0] p;
        if (fwd) begin
            case (sec)
                3'd1:    p = PhaseG;
                3'd2:    p = PhaseY;
                3'd3:    p = PhaseY;
                3'd4:    p = PhaseB;
                3'd5:    p = PhaseB;
                3'd6:    p = PhaseG;
                default: p = PhaseY;
            endcase
        end else begin
            case (sec)
                3'd1:    p = PhaseB;
                3'd2:    p = PhaseB;
                3'd3:    p = PhaseG;
                3'd4:    p = PhaseG;
                3'd5:    p = PhaseY;
                3'd6:    p = PhaseY;
                default: p = PhaseY;
            endcase
        end
        return p;
    endfunction

    function automatic t_mode phase_mode(input logic [1:0] ph, input logic [1:0] hi,
                                         input logic [1:0] lo);
        t_mode m;
        if (ph == hi) begin
            m = ModePwm;
        end else if (ph == lo) begin
            m = ModeLow;
        end else begin
            m = ModeFloat;
        end
        return m;
    endfunction

    function automatic t_modes drive_modes(input logic [SecW-1:0] sec, input logic fwd);
        logic [1:0] hi;
        logic [1:0] lo;
        t_modes     m;
        hi  = pwm_phase(sec, fwd);
        lo  = pwm_phase(sec, !fwd);
        m.y = phase_mode(PhaseY, hi, lo);
        m.b = phase_mode(PhaseB, hi, lo);
        m.g = phase_mode(PhaseG, hi, lo);
        return m;
    endfunction

endpackage

// File: src/hssc_if.sv
interface hssc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [2:0]                           op;
    logic                                 hall_a;
    logic                                 hall_b;
    logic                                 hall_c;
    logic signed [hssc_pkg::CmdW-1:0]     pwm_value;
    logic [hssc_pkg::RampMsW-1:0]         ramp_ms;

    modport source (output valid, op, hall_a, hall_b, hall_c, pwm_value, ramp_ms,
                    input ready);
    modport sink (input valid, op, hall_a, hall_b, hall_c, pwm_value, ramp_ms,
                  output ready);
endinterface

interface hssc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [hssc_pkg::ModeW-1:0]           phase_y_mode;
    logic [hssc_pkg::ModeW-1:0]           phase_b_mode;
    logic [hssc_pkg::ModeW-1:0]           phase_g_mode;
    logic [hssc_pkg::DutyW-1:0]           compare_value;
    logic [hssc_pkg::SecW-1:0]            sector;
    logic signed [hssc_pkg::PosW-1:0]     position_count;
    logic                                 ramp_busy;
    logic signed [hssc_pkg::CmdW-1:0]     user_command;
    logic                                 drive_enabled;

    modport source (output valid, phase_y_mode, phase_b_mode, phase_g_mode, compare_value,
                    sector, position_count, ramp_busy, user_command, drive_enabled,
                    input ready);
    modport sink (input valid, phase_y_mode, phase_b_mode, phase_g_mode, compare_value,
                  sector, position_count, ramp_busy, user_command, drive_enabled,
                  output ready);
endinterface

// File: src/hall_six_step_commutator.sv
// Flow: enable, disable, clear and unused ops go from dispatch to the result; a tick decodes
// the sector, after first applying the next command when it steps a ramp; a set pwm rescales
// the duty only for a new command; a zero-length ramp start ends after setup, any other
// runs the 32-step serial slope divider. One item at a time, the next accepted in the cycle
// after a result is loaded; a stalled result holds the block until it is taken.
// Reset: synchronous, active low; drive off, no ramp, position 0, max_duty 1000, tpm 10.
module hall_six_step_commutator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    hssc_in_if.sink                            i_item,
    hssc_out_if.source                         o_result,
    input  logic                               i_cfg_we,
    input  logic [hssc_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [hssc_pkg::CfgDataW-1:0]      i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RAMP_MUL,
        S_RAMP_CMD,
        S_APPLY,
        S_DUTY_MUL,
        S_DUTY_SCALE,
        S_END_MUL,
        S_SLOPE_SETUP,
        S_DIV,
        S_DIV_DONE,
        S_DECODE,
        S_DONE
    } t_state;

    t_state                           r_state;
    logic [2:0]                       r_op;
    logic                             r_hall_a;
    logic                             r_hall_b;
    logic                             r_hall_c;
    logic [hssc_pkg::CmdW-1:0]        r_pwm_value;
    logic [hssc_pkg::RampMsW-1:0]     r_ramp_ms;
    logic [hssc_pkg::DutyW-1:0]       r_max_duty;
    logic [hssc_pkg::TpmW-1:0]        r_tpm;
    logic                             r_enabled;
    logic                             r_fwd;
    logic [hssc_pkg::DutyW-1:0]       r_duty;
    logic [hssc_pkg::CmdW-1:0]        r_last_cmd;
    logic                             r_ramp_on;
    logic [hssc_pkg::RampW-1:0]       r_count;
    logic [hssc_pkg::RampW-1:0]       r_end;
    logic [hssc_pkg::SlopeW-1:0]      r_slope_mag;
    logic                             r_slope_neg;
    logic [hssc_pkg::CmdW-1:0]        r_ramp_start;
    logic [hssc_pkg::SecW-1:0]        r_prev_sector;
    logic                             r_prev_valid;
    logic [hssc_pkg::PosW-1:0]        r_position;
    logic [hssc_pkg::CmdW-1:0]        r_cmd;
    logic [hssc_pkg::MagW-1:0]        r_mag;
    logic [hssc_pkg::RampW-1:0]       r_prod;
    logic [hssc_pkg::RampW-1:0]       r_rem;
    logic [hssc_pkg::DivW-1:0]        r_quo;
    logic [hssc_pkg::DivCntW-1:0]     r_cnt;
    logic                             r_out_valid;
    hssc_pkg::t_modes                 r_out_modes;
    logic [hssc_pkg::DutyW-1:0]       r_out_cmp;
    logic [hssc_pkg::SecW-1:0]        r_out_sec;
    logic [hssc_pkg::PosW-1:0]        r_out_pos;
    logic                             r_out_busy;
    logic [hssc_pkg::CmdW-1:0]        r_out_cmd;
    logic                             r_out_en;

    logic [hssc_pkg::MulAW-1:0]               mul_a;
    logic [hssc_pkg::MulBW-1:0]               mul_b;
    logic [hssc_pkg::MulAW+hssc_pkg::MulBW-1:0] mul_full;
    logic [hssc_pkg::DivW-1:0]                mul_p;
    logic [hssc_pkg::CmdW:0]                  cmd_ext;
    logic [hssc_pkg::CmdW:0]                  cmd_abs;
    logic [hssc_pkg::MagW-1:0]                cmd_mag;
    logic [hssc_pkg::CmdW:0]                  diff;
    logic [hssc_pkg::CmdW:0]                  diff_abs;
    logic [hssc_pkg::CmdW-1:0]                ramp_r;
    logic [hssc_pkg::CmdW-1:0]                ramp_cmd;
    logic [hssc_pkg::RampW-1:0]               div_dvsr;
    logic [hssc_pkg::RampW:0]                 div_sh;
    logic [hssc_pkg::RampW:0]                 div_sub;
    logic                                     div_ge;
    logic [hssc_pkg::SecW-1:0]                sec;
    logic                                     pos_up;
    logic                                     pos_dn;
    logic                                     is_tick;
    hssc_pkg::t_modes                         modes_now;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_RAMP_MUL: begin
                mul_a = r_slope_mag;
                mul_b = r_count;
            end
            S_DUTY_MUL: begin
                mul_a = hssc_pkg::MulAW'(r_mag);
                mul_b = hssc_pkg::MulBW'(r_max_duty);
            end
            S_DUTY_SCALE: begin
                mul_a = hssc_pkg::DutyRecip;
                mul_b = r_prod;
            end
            S_END_MUL: begin
                mul_a = hssc_pkg::MulAW'(r_ramp_ms);
                mul_b = hssc_pkg::MulBW'(r_tpm);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_p    = mul_full[hssc_pkg::DivW-1:0];

    assign cmd_ext = {r_cmd[hssc_pkg::CmdW-1], r_cmd};
    assign cmd_abs = r_cmd[hssc_pkg::CmdW-1] ? (~cmd_ext + 1'b1) : cmd_ext;
    assign cmd_mag = (cmd_abs > (hssc_pkg::CmdW+1)'(hssc_pkg::CmdLimit))
                   ? hssc_pkg::MagW'(hssc_pkg::CmdLimit) : cmd_abs[hssc_pkg::MagW-1:0];

    assign diff     = {r_pwm_value[hssc_pkg::CmdW-1], r_pwm_value}
                    - {r_last_cmd[hssc_pkg::CmdW-1], r_last_cmd};
    assign diff_abs = diff[hssc_pkg::CmdW] ? (~diff + 1'b1) : diff;

    assign ramp_r   = r_quo[31:16] + hssc_pkg::CmdW'(r_quo[15]);
    assign ramp_cmd = r_slope_neg ? (r_ramp_start - ramp_r) : (r_ramp_start + ramp_r);

    assign div_dvsr = r_end;
    assign div_sh   = {r_rem, r_quo[hssc_pkg::DivW-1]};
    assign div_ge   = (div_sh >= {1'b0, div_dvsr});
    assign div_sub  = div_sh - {1'b0, div_dvsr};

    assign sec = hssc_pkg::hall_sector(r_hall_a, r_hall_b, r_hall_c);

    always_comb begin
        pos_up = 1'b0;
        pos_dn = 1'b0;
        if (sec == 3'd1 && r_prev_sector == 3'd6) begin
            pos_up = 1'b1;
        end else if (sec == 3'd6 && r_prev_sector == 3'd1) begin
            pos_dn = 1'b1;
        end else if (sec > r_prev_sector) begin
            pos_up = 1'b1;
        end else if (sec < r_prev_sector) begin
            pos_dn = 1'b1;
        end
    end

    assign is_tick   = (r_op == hssc_pkg::OpTick);
    assign modes_now = hssc_pkg::drive_modes(r_prev_sector, r_fwd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_max_duty    <= hssc_pkg::MaxDutyReset;
            r_tpm         <= hssc_pkg::TpmReset;
            r_enabled     <= 1'b0;
            r_fwd         <= 1'b0;
            r_duty        <= '0;
            r_last_cmd    <= '0;
            r_ramp_on     <= 1'b0;
            r_count       <= '0;
            r_end         <= '0;
            r_slope_mag   <= '0;
            r_slope_neg   <= 1'b0;
            r_ramp_start  <= '0;
            r_prev_sector <= '0;
            r_prev_valid  <= 1'b0;
            r_position    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hssc_pkg::CfgMaxDuty:    r_max_duty <= i_cfg_data;
                    hssc_pkg::CfgTicksPerMs: r_tpm      <= i_cfg_data[hssc_pkg::TpmW-1:0];
                    default:                 r_tpm      <= r_tpm;
                endcase
            end

            if (o_result.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_op        <= i_item.op;
                        r_hall_a    <= i_item.hall_a;
                        r_hall_b    <= i_item.hall_b;
                        r_hall_c    <= i_item.hall_c;
                        r_pwm_value <= i_item.pwm_value;
                        r_ramp_ms   <= i_item.ramp_ms;
                        r_state     <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    case (r_op)
                        hssc_pkg::OpTick: begin
                            if (r_ramp_on && (r_count > r_end)) begin
                                r_ramp_on <= 1'b0;
                                r_state   <= S_DECODE;
                            end else if (r_ramp_on) begin
                                r_state <= S_RAMP_MUL;
                            end else begin
                                r_state <= S_DECODE;
                            end
                        end
                        hssc_pkg::OpSetPwm: begin
                            r_cmd   <= r_pwm_value;
                            r_state <= S_APPLY;
                        end
                        hssc_pkg::OpStartRamp: begin
                            r_state <= S_END_MUL;
                        end
                        hssc_pkg::OpEnable: begin
                            r_enabled <= 1'b1;
                            r_state   <= S_DONE;
                        end
                        hssc_pkg::OpDisable: begin
                            r_enabled <= 1'b0;
                            r_duty    <= '0;
                            r_ramp_on <= 1'b0;
                            r_state   <= S_DONE;
                        end
                        hssc_pkg::OpClearPos: begin
                            r_position <= '0;
                            r_state    <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_RAMP_MUL: begin
                    r_quo   <= mul_p;
                    r_state <= S_RAMP_CMD;
                end
                S_RAMP_CMD: begin
                    r_cmd   <= ramp_cmd;
                    r_count <= r_count + 1'b1;
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (r_cmd == r_last_cmd) begin
                        r_state <= is_tick ? S_DECODE : S_DONE;
                    end else begin
                        r_last_cmd <= r_cmd;
                        r_fwd      <= ~r_cmd[hssc_pkg::CmdW-1];
                        r_mag      <= cmd_mag;
                        r_state    <= S_DUTY_MUL;
                    end
                end
                S_DUTY_MUL: begin
                    r_prod  <= mul_p[hssc_pkg::RampW-1:0];
                    r_state <= S_DUTY_SCALE;
                end
                S_DUTY_SCALE: begin
                    r_duty  <= mul_full[hssc_pkg::DutyShift +: hssc_pkg::DutyW];
                    r_state <= is_tick ? S_DECODE : S_DONE;
                end
                S_END_MUL: begin
                    r_end   <= mul_p[hssc_pkg::RampW-1:0];
                    r_state <= S_SLOPE_SETUP;
                end
                S_SLOPE_SETUP: begin
                    r_count   <= '0;
                    r_ramp_on <= 1'b1;
                    if (r_end == '0) begin
                        r_ramp_start <= r_pwm_value;
                        r_slope_mag  <= '0;
                        r_slope_neg  <= 1'b0;
                        r_state      <= S_DONE;
                    end else begin
                        r_ramp_start <= r_last_cmd;
                        r_slope_neg  <= diff[hssc_pkg::CmdW];
                        r_quo        <= {diff_abs[hssc_pkg::CmdW-1:0], {hssc_pkg::CmdW{1'b0}}};
                        r_rem        <= '0;
                        r_cnt        <= '0;
                        r_state      <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? div_sub[hssc_pkg::RampW-1:0] : div_sh[hssc_pkg::RampW-1:0];
                    r_quo <= {r_quo[hssc_pkg::DivW-2:0], div_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == hssc_pkg::DivCntW'(hssc_pkg::DivSteps - 1)) begin
                        r_state <= S_DIV_DONE;
                    end
                end
                S_DIV_DONE: begin
                    r_slope_mag <= r_quo;
                    r_state     <= S_DONE;
                end
                S_DECODE: begin
                    if (r_prev_valid && pos_up) begin
                        r_position <= r_position + 1'b1;
                    end else if (r_prev_valid && pos_dn) begin
                        r_position <= r_position - 1'b1;
                    end
                    r_prev_sector <= sec;
                    r_prev_valid  <= 1'b1;
                    r_state       <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        if (is_tick && r_enabled && (r_prev_sector != '0)) begin
                            r_out_modes <= modes_now;
                            r_out_cmp   <= r_duty;
                        end else begin
                            r_out_modes <= '{hssc_pkg::ModeFloat, hssc_pkg::ModeFloat,
                                             hssc_pkg::ModeFloat};
                            r_out_cmp   <= '0;
                        end
                        r_out_sec  <= is_tick ? r_prev_sector : '0;
                        r_out_pos  <= r_position;
                        r_out_busy <= r_ramp_on;
                        r_out_cmd  <= r_last_cmd;
                        r_out_en   <= r_enabled;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready            = (r_state == S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.phase_y_mode   = r_out_modes.y;
    assign o_result.phase_b_mode   = r_out_modes.b;
    assign o_result.phase_g_mode   = r_out_modes.g;
    assign o_result.compare_value  = r_out_cmp;
    assign o_result.sector         = r_out_sec;
    assign o_result.position_count = $signed(r_out_pos);
    assign o_result.ramp_busy      = r_out_busy;
    assign o_result.user_command   = $signed(r_out_cmd);
    assign o_result.drive_enabled  = r_out_en;

endmodule

// File: src/hssc_checker.sv
module hssc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [hssc_pkg::ModeW-1:0]       i_y_mode,
    input  logic [hssc_pkg::ModeW-1:0]       i_b_mode,
    input  logic [hssc_pkg::ModeW-1:0]       i_g_mode,
    input  logic [hssc_pkg::DutyW-1:0]       i_compare,
    input  logic [hssc_pkg::SecW-1:0]        i_sector,
    input  logic                             i_enabled
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("block ready right after accepting an item");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_compare) && $stable(i_sector))
        else $error("stalled result item changed");

    a_no_sector_float: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_sector == '0) |->
            i_y_mode == hssc_pkg::ModeFloat && i_b_mode == hssc_pkg::ModeFloat &&
            i_g_mode == hssc_pkg::ModeFloat && i_compare == '0)
        else $error("phases driven without a valid sector");

    a_disabled_float: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_enabled |->
            i_y_mode == hssc_pkg::ModeFloat && i_b_mode == hssc_pkg::ModeFloat &&
            i_g_mode == hssc_pkg::ModeFloat && i_compare == '0)
        else $error("phases driven while drive disabled");

    a_compare_has_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_compare != '0) |->
            i_y_mode == hssc_pkg::ModePwm || i_b_mode == hssc_pkg::ModePwm ||
            i_g_mode == hssc_pkg::ModePwm)
        else $error("compare value set with no pwm phase");

endmodule

bind hall_six_step_commutator hssc_checker u_hssc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_y_mode    (o_result.phase_y_mode),
    .i_b_mode    (o_result.phase_b_mode),
    .i_g_mode    (o_result.phase_g_mode),
    .i_compare   (o_result.compare_value),
    .i_sector    (o_result.sector),
    .i_enabled   (o_result.drive_enabled)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] OpSpareLo = 3'd6;
    localparam logic [2:0] OpSpareHi = 3'd7;
    localparam int QuietLimit = 3000;
    localparam int SettleCycles = 50;

    // sector per hall pattern {a,b,c}, pattern 7 at the top
    localparam logic [23:0] HallSector = {3'd0, 3'd4, 3'd2, 3'd3, 3'd6, 3'd5, 3'd1, 3'd0};
    // hall pattern per sector, sector 6 at the top
    localparam logic [20:0] SectorHall = {3'b011, 3'b010, 3'b110, 3'b100, 3'b101, 3'b001,
                                          3'b000};
    // pwm leg per sector for each direction, sector 6 at the top
    localparam logic [13:0] LegFwd = {2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd0};
    localparam logic [13:0] LegRev = {2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0};

    typedef struct packed {
        logic [2:0]         op;
        logic [2:0]         hall;
        logic signed [15:0] pwm;
        logic [15:0]        ms;
    } t_cmd_item;

    typedef struct packed {
        hssc_pkg::t_mode    y;
        hssc_pkg::t_mode    b;
        hssc_pkg::t_mode    g;
        logic [15:0]        cmp;
        logic [2:0]         sec;
        logic signed [31:0] pos;
        logic               busy;
        logic signed [15:0] cmd;
        logic               en;
    } t_drive;

    typedef struct packed {
        t_cmd_item it;
        logic      typed;
        t_drive    exp;
    } t_row;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [hssc_pkg::CfgIdxW-1:0] cfg_idx;
    logic [hssc_pkg::CfgDataW-1:0] cfg_data;

    hssc_in_if in_ch ();
    hssc_out_if out_ch ();

    hall_six_step_commutator dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_item    (in_ch),
        .o_result  (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [15:0]        cfg_max_duty = hssc_pkg::MaxDutyReset;
    logic [9:0]         cfg_tpm = hssc_pkg::TpmReset;
    logic               drv_on = 1'b0;
    logic               fwd = 1'b0;
    logic [15:0]        duty_q = '0;
    logic signed [15:0] cmd_last = '0;
    logic               rmp_on = 1'b0;
    logic [25:0]        rmp_cnt = '0;
    logic [25:0]        rmp_end = '0;
    longint             rmp_slope = 0;
    int                 rmp_base = 0;
    logic [2:0]         last_sec = '0;
    logic               sec_seen = 1'b0;
    logic signed [31:0] pos_cnt = '0;

    t_drive drive_q[$];
    t_row   rows[$];
    int     n_fail = 0;
    int     src_pct = 0;
    int     sink_pct = 0;
    int     hold_len = 0;
    int     rotor = 1;
    bit     spin_fwd = 1'b1;

    function automatic void take_command(input logic signed [15:0] c);
        int          lim;
        int unsigned mag;
        if (c == cmd_last) return;
        cmd_last = c;
        lim = c;
        if (lim > hssc_pkg::CmdLimit) lim = hssc_pkg::CmdLimit;
        if (lim < -hssc_pkg::CmdLimit) lim = -hssc_pkg::CmdLimit;
        fwd = (lim >= 0);
        mag = (lim < 0) ? -lim : lim;
        duty_q = 16'((mag * cfg_max_duty) / hssc_pkg::CmdLimit);
    endfunction

    function automatic t_drive next_drive(input t_cmd_item it);
        t_drive            r;
        hssc_pkg::t_mode   leg [3];
        logic [2:0]        sec;
        logic [1:0]        hi;
        logic [1:0]        lo;
        longint unsigned   mag;
        int                cmd_int;
        int                diff;
        r = '0;
        leg[0] = hssc_pkg::ModeFloat;
        leg[1] = hssc_pkg::ModeFloat;
        leg[2] = hssc_pkg::ModeFloat;
        sec = '0;
        case (it.op)
            hssc_pkg::OpTick: begin
                if (rmp_on) begin
                    if (rmp_cnt > rmp_end) begin
                        rmp_on = 1'b0;
                    end else begin
                        mag = (rmp_slope < 0) ? -rmp_slope : rmp_slope;
                        mag = (mag * rmp_cnt + 64'h8000) >> 16;
                        cmd_int = (rmp_slope < 0) ? rmp_base - int'(mag) : rmp_base + int'(mag);
                        take_command(cmd_int[15:0]);
                        rmp_cnt = rmp_cnt + 26'd1;
                    end
                end
                sec = HallSector[it.hall*3 +: 3];
                if (drv_on && sec != 3'd0) begin
                    hi = fwd ? LegFwd[sec*2 +: 2] : LegRev[sec*2 +: 2];
                    lo = fwd ? LegRev[sec*2 +: 2] : LegFwd[sec*2 +: 2];
                    leg[hi] = hssc_pkg::ModePwm;
                    leg[lo] = hssc_pkg::ModeLow;
                    r.cmp = duty_q;
                end
                if (sec_seen) begin
                    if (sec == 3'd1 && last_sec == 3'd6) pos_cnt = pos_cnt + 1;
                    else if (sec == 3'd6 && last_sec == 3'd1) pos_cnt = pos_cnt - 1;
                    else if (sec > last_sec) pos_cnt = pos_cnt + 1;
                    else if (sec < last_sec) pos_cnt = pos_cnt - 1;
                end
                last_sec = sec;
                sec_seen = 1'b1;
            end
            hssc_pkg::OpSetPwm: take_command(it.pwm);
            hssc_pkg::OpStartRamp: begin
                rmp_end = 26'(32'(it.ms) * 32'(cfg_tpm));
                rmp_cnt = '0;
                if (rmp_end == '0) begin
                    rmp_base = it.pwm;
                    rmp_slope = 0;
                end else begin
                    diff = int'(it.pwm) - int'(cmd_last);
                    mag = (diff < 0) ? -diff : diff;
                    mag = (mag << 16) / rmp_end;
                    rmp_slope = (diff < 0) ? -longint'(mag) : longint'(mag);
                    rmp_base = cmd_last;
                end
                rmp_on = 1'b1;
            end
            hssc_pkg::OpEnable: drv_on = 1'b1;
            hssc_pkg::OpDisable: begin
                drv_on = 1'b0;
                duty_q = '0;
                rmp_on = 1'b0;
            end
            hssc_pkg::OpClearPos: pos_cnt = '0;
            default: ;
        endcase
        r.y = leg[0];
        r.b = leg[1];
        r.g = leg[2];
        r.sec = sec;
        r.pos = pos_cnt;
        r.busy = rmp_on;
        r.cmd = cmd_last;
        r.en = drv_on;
        return r;
    endfunction

    function automatic t_drive quiet(input logic signed [31:0] pos, input logic busy,
                                     input logic signed [15:0] cmd, input logic en);
        t_drive r;
        r = '0;
        r.pos = pos;
        r.busy = busy;
        r.cmd = cmd;
        r.en = en;
        return r;
    endfunction

    task automatic put(input logic [2:0] op, input logic [2:0] hall,
                       input logic signed [15:0] pwm, input logic [15:0] ms,
                       input logic typed, input t_drive exp);
        t_row r;
        r.it.op = op;
        r.it.hall = hall;
        r.it.pwm = pwm;
        r.it.ms = ms;
        r.typed = typed;
        r.exp = exp;
        rows.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    task automatic send(input t_cmd_item it, input logic typed, input t_drive typed_exp);
        t_drive pred;
        @(negedge clk);
        while (src_pct > 0 && $urandom_range(99) < src_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= it.op;
        in_ch.hall_a <= it.hall[2];
        in_ch.hall_b <= it.hall[1];
        in_ch.hall_c <= it.hall[0];
        in_ch.pwm_value <= it.pwm;
        in_ch.ramp_ms <= it.ms;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        pred = next_drive(it);
        drive_q.push_back(typed ? typed_exp : pred);
    endtask

    task automatic write_reg(input logic [hssc_pkg::CfgIdxW-1:0] idx,
                             input logic [hssc_pkg::CfgDataW-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        if (idx == hssc_pkg::CfgMaxDuty) cfg_max_duty = data;
        else cfg_tpm = data[hssc_pkg::TpmW-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge clk);
    endtask

    task automatic run_phase(input logic [15:0] max_duty, input logic [15:0] tpm,
                             input int src_idle, input int sink_idle, input int n_items,
                             input int hold);
        t_cmd_item it;
        int        n_done;
        int        pick;
        int        roll;
        write_reg(hssc_pkg::CfgMaxDuty, max_duty);
        write_reg(hssc_pkg::CfgTicksPerMs, tpm);
        src_pct = src_idle;
        sink_pct = sink_idle;
        hold_len = hold;
        n_done = 0;
        while (n_done < n_items) begin
            pick = $urandom_range(99);
            roll = $urandom_range(99);
            it.hall = 3'($urandom);
            it.pwm = 16'($urandom);
            it.ms = 16'($urandom);
            if (pick < 58) begin
                it.op = hssc_pkg::OpTick;
                if (roll < 75) begin
                    if (spin_fwd) rotor = (rotor == 6) ? 1 : rotor + 1;
                    else rotor = (rotor == 1) ? 6 : rotor - 1;
                    it.hall = SectorHall[rotor*3 +: 3];
                end else if (roll < 85) begin
                    it.hall = SectorHall[rotor*3 +: 3];
                end
                if ($urandom_range(49) == 0) spin_fwd = !spin_fwd;
            end else if (pick < 78) begin
                it.op = (pick < 70) ? hssc_pkg::OpSetPwm : hssc_pkg::OpStartRamp;
                if (roll < 70) it.pwm = 16'($urandom_range(2400) - 1200);
                else if (roll < 80) it.pwm = cmd_last;
                roll = $urandom_range(99);
                if (roll < 80) it.ms = 16'($urandom_range(6));
                else if (roll < 95) it.ms = 16'($urandom_range(60));
            end else if (pick < 86) begin
                it.op = hssc_pkg::OpEnable;
            end else if (pick < 90) begin
                it.op = hssc_pkg::OpDisable;
            end else if (pick < 96) begin
                it.op = hssc_pkg::OpClearPos;
            end else begin
                it.op = 3'($urandom_range(OpSpareHi, OpSpareLo));
            end
            send(it, 1'b0, '0);
            if (it.op <= hssc_pkg::OpClearPos) n_done++;
        end
        drain();
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_len > 0) begin
                out_ch.ready <= 1'b0;
                hold_len--;
            end else begin
                out_ch.ready <= !(sink_pct > 0 && $urandom_range(99) < sink_pct);
            end
        end
    end

    initial begin
        t_drive want;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (drive_q.size() == 0) begin
                    $error("result item with no command pending");
                    n_fail++;
                end else begin
                    want = drive_q.pop_front();
                    check_field("phase_y_mode", want.y, out_ch.phase_y_mode);
                    check_field("phase_b_mode", want.b, out_ch.phase_b_mode);
                    check_field("phase_g_mode", want.g, out_ch.phase_g_mode);
                    check_field("compare_value", want.cmp, out_ch.compare_value);
                    check_field("sector", want.sec, out_ch.sector);
                    check_field("position_count", want.pos, out_ch.position_count);
                    check_field("ramp_busy", want.busy, out_ch.ramp_busy);
                    check_field("user_command", want.cmd, out_ch.user_command);
                    check_field("drive_enabled", want.en, out_ch.drive_enabled);
                end
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QuietLimit) begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = hssc_pkg::OpTick;
        in_ch.hall_a = 1'b0;
        in_ch.hall_b = 1'b0;
        in_ch.hall_c = 1'b0;
        in_ch.pwm_value = '0;
        in_ch.ramp_ms = '0;

        put(hssc_pkg::OpTick, 3'b000, 16'sd0, 16'd0, 1'b1, quiet(0, 1'b0, 16'sd0, 1'b0));
        put(hssc_pkg::OpTick, 3'b111, -16'sd1, 16'hFFFF, 1'b1, quiet(0, 1'b0, 16'sd0, 1'b0));
        put(hssc_pkg::OpEnable, 3'b000, 16'sd0, 16'd0, 1'b1, quiet(0, 1'b0, 16'sd0, 1'b1));
        put(hssc_pkg::OpSetPwm, 3'b000, 16'sh7FFF, 16'd0, 1'b1,
            quiet(0, 1'b0, 16'sh7FFF, 1'b1));
        put(hssc_pkg::OpTick, 3'b001, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b101, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b100, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b110, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b010, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b011, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b001, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b011, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpSetPwm, 3'b000, 16'sh8000, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b001, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpSetPwm, 3'b000, 16'sh8000, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpClearPos, 3'b000, 16'sd0, 16'd0, 1'b1,
            quiet(0, 1'b0, 16'sh8000, 1'b1));
        put(hssc_pkg::OpStartRamp, 3'b000, 16'sd500, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b101, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b100, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b110, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpStartRamp, 3'b000, -16'sd1000, 16'hFFFF, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b010, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpSetPwm, 3'b000, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpTick, 3'b011, 16'sd0, 16'd0, 1'b0, '0);
        put(hssc_pkg::OpDisable, 3'b000, 16'sd0, 16'd0, 1'b0, '0);
        put(OpSpareLo, 3'b111, 16'sh7FFF, 16'hFFFF, 1'b0, '0);
        put(OpSpareHi, 3'b000, 16'sd0, 16'd0, 1'b0, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].exp);
        drain();

        run_phase(16'd1000, 16'd10, 0, 0, 150, 0);
        run_phase(16'hFFFF, 16'd1, 50, 0, 120, 0);
        run_phase(16'd0, 16'd0, 0, 50, 100, 0);
        run_phase(16'($urandom), 16'd1000, 23, 23, 130, 0);
        // hold the result side off long enough for the input to back up
        run_phase(16'd7, 16'hFFFF, 0, 0, 100, 400);

        repeat (SettleCycles) @(posedge clk);
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
